// ===== design/nprf_pkg.sv =====
// ============================================================================
// Newton root finder package
// Shared number format, saturating helpers, codes and sequencer states.
// ============================================================================
package nprf_pkg;

    localparam int FRAC_BITS = 32;
    localparam int WORD_W    = 64;
    localparam int WIDE_W    = 2 * WORD_W;
    localparam int HALF_W    = WORD_W / 2;
    localparam int GUESS_W   = 39;
    localparam int STEP_W    = 4;
    localparam int TOL_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = WIDE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0]        umag_t;
    typedef logic [WIDE_W-1:0]        wide_t;

    typedef struct packed {
        logic  sat;
        word_t value;
    } fx_res_t;

    localparam word_t ONE = word_t'(64'd1 << FRAC_BITS);
    localparam word_t C43 = word_t'(((64'd8 << FRAC_BITS) + 64'd3) / 64'd6);

    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_STEP_LIMIT = 2'd1,
        ST_ZERO_DERIV = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_SEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_SUB,
        S_X2,
        S_X4,
        S_X5,
        S_F_SUB1,
        S_F_SUB2,
        S_FMUL,
        S_CHECK,
        S_D_ADD,
        S_D_SUB,
        S_D_CHECK,
        S_DIV,
        S_UPD,
        S_OUT
    } state_t;

    function automatic umag_t mag_of(input word_t v);
        umag_t u;
        u = umag_t'(v);
        return u[WORD_W-1] ? (~u + umag_t'(1)) : u;
    endfunction

    function automatic fx_res_t sat_pack(input logic neg, input wide_t m);
        wide_t   lim;
        wide_t   mm;
        fx_res_t r;
        lim = wide_t'(1) << (WORD_W - 1);
        if (!neg) begin
            lim = lim - wide_t'(1);
        end
        r.sat = (m > lim);
        mm = r.sat ? lim : m;
        r.value = neg ? word_t'(-mm[WORD_W-1:0]) : word_t'(mm[WORD_W-1:0]);
        return r;
    endfunction

    function automatic fx_res_t fx_addsub(input word_t a, input word_t b, input logic sub);
        logic  na;
        logic  nb;
        umag_t ma;
        umag_t mb;
        wide_t s;
        logic  neg;
        na = a[WORD_W-1];
        nb = b[WORD_W-1] ^ sub;
        ma = mag_of(a);
        mb = mag_of(b);
        if (na == nb) begin
            s   = wide_t'(ma) + wide_t'(mb);
            neg = na;
        end else if (ma >= mb) begin
            s   = wide_t'(ma - mb);
            neg = na;
        end else begin
            s   = wide_t'(mb - ma);
            neg = nb;
        end
        return sat_pack(neg, s);
    endfunction

endpackage

// ===== design/newton_polynomial_root_finder_core.sv =====
// ============================================================================
// Newton polynomial root finder core
// Each Newton update uses the bit-serial divider, and at most fifteen updates
// are made per guess.
// Throughput: one item at a time; a new guess is taken the cycle after the
// result has been placed in the output register, so a stalled result holds the
// input off. Reset is asynchronous and active low; it clears control state and
// loads the register defaults.
// ============================================================================
module newton_polynomial_root_finder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [nprf_pkg::GUESS_W-1:0] start_point,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [nprf_pkg::WORD_W-1:0]  root_estimate,
    output logic [nprf_pkg::STEP_W-1:0]      steps_used,
    output logic [1:0]                       status,
    input  logic                             cfg_wen,
    input  logic [nprf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nprf_pkg::TOL_W-1:0]       cfg_wdata
);
    import nprf_pkg::*;

    state_t             state_reg, state_next;
    logic               func_sel_reg;
    logic [STEP_W-1:0]  max_steps_reg;
    logic [TOL_W-1:0]   tol_reg;
    word_t              x_reg, x_next;
    word_t              fx_reg, fx_next;
    word_t              t_reg, t_next;
    word_t              x4_reg, x4_next;
    word_t              acc_reg, acc_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               sat_reg, sat_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               issued_reg, issued_next;
    status_t            stat_reg, stat_next;
    logic               out_valid_reg, out_valid_next;
    word_t              root_reg;
    logic [STEP_W-1:0]  steps_out_reg;
    status_t            status_out_reg;
    logic               out_load;

    word_t              add_a, add_b;
    logic               add_sub;
    fx_res_t            add_res;
    word_t              mul_a, mul_b;
    logic               mul_start, mul_done;
    fx_res_t            mul_res;
    logic               div_start, div_done;
    fx_res_t            div_res;
    umag_t              residual;
    logic               small_res;
    logic               in_xfer;

    assign in_xfer   = in_valid && !in_stall;
    assign residual  = mag_of(fx_reg);
    assign small_res = (residual <= umag_t'(tol_reg));
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign add_res   = fx_addsub(add_a, add_b, add_sub);

    nprf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    nprf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .n      (fx_reg),
        .d      (acc_reg),
        .done   (div_done),
        .result (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    state_next = func_sel_reg ? S_X2 : S_Q_SUB;
                end
            end
            S_Q_SUB:  state_next = S_FMUL;
            S_X2:     state_next = mul_done ? S_X4 : S_X2;
            S_X4:     state_next = mul_done ? S_X5 : S_X4;
            S_X5:     state_next = mul_done ? S_F_SUB1 : S_X5;
            S_F_SUB1: state_next = S_F_SUB2;
            S_F_SUB2: state_next = S_CHECK;
            S_FMUL:   state_next = mul_done ? S_CHECK : S_FMUL;
            S_CHECK:
            begin
                if (sat_reg || small_res || steps_reg >= max_steps_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_D_ADD;
                end
            end
            S_D_ADD:
            begin
                if (!func_sel_reg || cnt_reg == 2'd0) begin
                    state_next = S_D_SUB;
                end
            end
            S_D_SUB:  state_next = S_D_CHECK;
            S_D_CHECK:
            begin
                if (sat_reg || acc_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV:    state_next = div_done ? S_UPD : S_DIV;
            S_UPD:
            begin
                if (sat_reg || add_res.sat) begin
                    state_next = S_OUT;
                end else begin
                    state_next = func_sel_reg ? S_X2 : S_Q_SUB;
                end
            end
            S_OUT:    state_next = out_load ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        add_a       = x_reg;
        add_b       = C43;
        add_sub     = 1'b1;
        mul_a       = x_reg;
        mul_b       = x_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        x_next      = x_reg;
        fx_next     = fx_reg;
        t_next      = t_reg;
        x4_next     = x4_reg;
        acc_next    = acc_reg;
        steps_next  = steps_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        issued_next = issued_reg;
        stat_next   = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    x_next     = {{(WORD_W - GUESS_W){start_point[GUESS_W-1]}}, start_point};
                    steps_next = '0;
                    sat_next   = 1'b0;
                end
            end
            S_Q_SUB:
            begin
                t_next   = add_res.value;
                sat_next = sat_reg | add_res.sat;
            end
            S_X2, S_X4, S_X5, S_FMUL:
            begin
                if (state_reg == S_X4) begin
                    mul_a = t_reg;
                    mul_b = t_reg;
                end else if (state_reg == S_X5) begin
                    mul_a = x4_reg;
                end else if (state_reg == S_FMUL) begin
                    mul_b = t_reg;
                end
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    issued_next = 1'b0;
                    sat_next    = sat_reg | mul_res.sat;
                    case (state_reg)
                        S_X4:    x4_next = mul_res.value;
                        S_FMUL:  fx_next = mul_res.value;
                        default: t_next  = mul_res.value;
                    endcase
                end
            end
            S_F_SUB1:
            begin
                add_a    = t_reg;
                add_b    = x_reg;
                t_next   = add_res.value;
                sat_next = sat_reg | add_res.sat;
            end
            S_F_SUB2:
            begin
                add_a    = t_reg;
                add_b    = ONE;
                fx_next  = add_res.value;
                sat_next = sat_reg | add_res.sat;
            end
            S_CHECK:
            begin
                acc_next = x4_reg;
                cnt_next = 2'd3;
                if (sat_reg) begin
                    stat_next = ST_OVERFLOW;
                end else if (small_res) begin
                    stat_next = ST_CONVERGED;
                end else begin
                    stat_next = ST_STEP_LIMIT;
                end
            end
            S_D_ADD:
            begin
                add_sub = 1'b0;
                if (func_sel_reg) begin
                    add_a = acc_reg;
                    add_b = x4_reg;
                end else begin
                    add_b = x_reg;
                end
                acc_next = add_res.value;
                sat_next = sat_reg | add_res.sat;
                cnt_next = cnt_reg - 2'd1;
            end
            S_D_SUB:
            begin
                add_a    = acc_reg;
                add_b    = func_sel_reg ? ONE : C43;
                acc_next = add_res.value;
                sat_next = sat_reg | add_res.sat;
            end
            S_D_CHECK:
            begin
                stat_next = sat_reg ? ST_OVERFLOW : ST_ZERO_DERIV;
            end
            S_DIV:
            begin
                div_start   = !issued_reg;
                issued_next = 1'b1;
                if (div_done) begin
                    issued_next = 1'b0;
                    t_next      = div_res.value;
                    sat_next    = sat_reg | div_res.sat;
                end
            end
            S_UPD:
            begin
                add_b      = t_reg;
                x_next     = add_res.value;
                sat_next   = sat_reg | add_res.sat;
                steps_next = steps_reg + STEP_W'(1);
                stat_next  = ST_OVERFLOW;
            end
            default:
            begin
            end
        endcase
        out_valid_next = out_valid_reg && out_stall;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            func_sel_reg  <= 1'b1;
            max_steps_reg <= STEP_W'(9);
            tol_reg       <= TOL_W'(1);
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_FUNC_SEL:  func_sel_reg  <= cfg_wdata[0];
                    CFG_MAX_STEPS: max_steps_reg <= cfg_wdata[STEP_W-1:0];
                    CFG_TOLERANCE: tol_reg       <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        fx_reg    <= fx_next;
        t_reg     <= t_next;
        x4_reg    <= x4_next;
        acc_reg   <= acc_next;
        steps_reg <= steps_next;
        sat_reg   <= sat_next;
        cnt_reg   <= cnt_next;
        stat_reg  <= stat_next;
        if (out_load) begin
            root_reg       <= x_reg;
            steps_out_reg  <= steps_reg;
            status_out_reg <= stat_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign root_estimate = root_reg;
    assign steps_used    = steps_out_reg;
    assign status        = status_out_reg;

endmodule

// ===== design/nprf_mul.sv =====
// ============================================================================
// Newton root finder multiplier
// Multi-cycle signed fixed-point multiply from four 32x32 partial products,
// rounded to nearest with ties away from zero and saturated.
// ============================================================================
module nprf_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  nprf_pkg::word_t  a,
    input  nprf_pkg::word_t  b,
    output logic             done,
    output nprf_pkg::fx_res_t result
);
    import nprf_pkg::*;

    umag_t              ma_reg, ma_next;
    umag_t              mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [WORD_W-1:0]  pp_reg, pp_next;
    logic [1:0]         pp_idx_reg, pp_idx_next;
    wide_t              acc_reg, acc_next;
    logic               done_reg, done_next;
    fx_res_t            res_reg, res_next;
    logic [HALF_W-1:0]  op_a, op_b;
    wide_t              pp_shifted;
    wide_t              rounded;

    always_comb
    begin
        op_a = cnt_reg[1] ? ma_reg[WORD_W-1:HALF_W] : ma_reg[HALF_W-1:0];
        op_b = cnt_reg[0] ? mb_reg[WORD_W-1:HALF_W] : mb_reg[HALF_W-1:0];
        case (pp_idx_reg)
            2'd0:    pp_shifted = wide_t'(pp_reg);
            2'd3:    pp_shifted = wide_t'(pp_reg) << WORD_W;
            default: pp_shifted = wide_t'(pp_reg) << HALF_W;
        endcase
        rounded = acc_reg + (wide_t'(1) << (FRAC_BITS - 1));
    end

    always_comb
    begin
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        pp_next     = pp_reg;
        pp_idx_next = pp_idx_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        if (start) begin
            ma_next   = mag_of(a);
            mb_next   = mag_of(b);
            neg_next  = a[WORD_W-1] ^ b[WORD_W-1];
            acc_next  = '0;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            pp_next     = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
            pp_idx_next = cnt_reg[1:0];
            if (cnt_reg != 3'd0 && cnt_reg != 3'd5) begin
                acc_next = acc_reg + pp_shifted;
            end
            if (cnt_reg == 3'd5) begin
                res_next  = sat_pack(neg_reg, rounded >> FRAC_BITS);
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        pp_reg     <= pp_next;
        pp_idx_reg <= pp_idx_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== design/nprf_div.sv =====
// ============================================================================
// Newton root finder divider
// Bit-serial restoring division of a fixed-point numerator by a nonzero
// denominator, one quotient bit per cycle, rounded and saturated at the end.
// ============================================================================
module nprf_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  nprf_pkg::word_t  n,
    input  nprf_pkg::word_t  d,
    output logic             done,
    output nprf_pkg::fx_res_t result
);
    import nprf_pkg::*;

    wide_t                dvd_reg, dvd_next;
    umag_t                rem_reg, rem_next;
    umag_t                dm_reg, dm_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    fx_res_t              res_reg, res_next;
    logic [WORD_W:0]      rem_sh;
    logic                 ge;
    logic                 rnd;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[WIDE_W-1]};
        ge     = (rem_sh >= {1'b0, dm_reg});
        rnd    = (rem_reg >= (dm_reg - rem_reg));
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            dvd_next  = wide_t'(mag_of(n)) << FRAC_BITS;
            rem_next  = '0;
            dm_next   = mag_of(d);
            neg_next  = n[WORD_W-1] ^ d[WORD_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS)) begin
                res_next  = sat_pack(neg_reg, dvd_reg + wide_t'(rnd));
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next = ge ? umag_t'(rem_sh - {1'b0, dm_reg}) : rem_sh[WORD_W-1:0];
                dvd_next = {dvd_reg[WIDE_W-2:0], ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== design/nprf_checker.sv =====
// ============================================================================
// Newton root finder port checker
// Watches the top-level ports for output hold and busy behavior.
// ============================================================================
module nprf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] root_estimate,
    input logic [3:0]  steps_used,
    input logic [1:0]  status
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_estimate)
            && $stable(steps_used) && $stable(status))
        else $error("stalled result changed");

    // The block is busy right after it takes a guess.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("guess taken while not busy afterward");

    // No result appears in the cycle right after a guess transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

    // A new result is only produced while the input side is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

endmodule

bind newton_polynomial_root_finder_core nprf_checker u_nprf_checker (.*);

// ===== sim/newton_polynomial_root_finder_core_test.sv =====
// ============================================================================
// Newton root finder core testbench
// Drives starting guesses under random idling and stalls, predicts each
// result with a bit-exact fixed-point Newton iteration unless the row gives it, and compares fields.
// ============================================================================
module newton_polynomial_root_finder_core_test;
    import nprf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 3000;

    typedef struct {
        word_t               root;
        logic [STEP_W-1:0]   steps;
        status_t             stat;
    } root_result_t;

    typedef struct {
        logic signed [GUESS_W-1:0] guess;
        logic                      has_fixed;
        root_result_t              fixed;
    } guess_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [GUESS_W-1:0] start_point = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [WORD_W-1:0] root_estimate;
    logic [STEP_W-1:0] steps_used;
    logic [1:0] status;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FUNC_SEL;
    logic [TOL_W-1:0] cfg_wdata = '0;

    logic              poly_quintic;
    logic [STEP_W-1:0] step_limit;
    logic [TOL_W-1:0]  tolerance;
    logic              sat_seen;

    root_result_t pending_roots[$];
    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    int  idle_count = 0;

    newton_polynomial_root_finder_core u_top (.*);

    always #6 clk = ~clk;

    function automatic word_t sat_word(input logic neg, input logic [191:0] m);
        logic [191:0] lim;
        lim = 192'd1 << 63;
        if (!neg) lim = lim - 1;
        if (m > lim)
        begin
            sat_seen = 1'b1;
            m = lim;
        end
        return neg ? word_t'(-m[63:0]) : word_t'(m[63:0]);
    endfunction

    function automatic logic [63:0] abs_word(input word_t v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic word_t add_word(input word_t a, input word_t b, input logic sub);
        logic na;
        logic nb;
        logic [63:0] ma;
        logic [63:0] mb;
        na = a[63];
        nb = b[63] ^ sub;
        ma = abs_word(a);
        mb = abs_word(b);
        if (na == nb) return sat_word(na, 192'(ma) + 192'(mb));
        if (ma >= mb) return sat_word(na, 192'(ma - mb));
        return sat_word(nb, 192'(mb - ma));
    endfunction

    function automatic word_t mul_word(input word_t a, input word_t b);
        logic [191:0] p;
        p = 192'(abs_word(a)) * 192'(abs_word(b));
        p = (p + (192'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return sat_word(a[63] ^ b[63], p);
    endfunction

    function automatic word_t div_word(input word_t n, input word_t d);
        logic [191:0] num;
        logic [191:0] dm;
        logic [191:0] q;
        logic [191:0] r;
        num = 192'(abs_word(n)) << FRAC_BITS;
        dm = 192'(abs_word(d));
        q = num / dm;
        r = num % dm;
        if (r >= dm - r) q = q + 1;
        return sat_word(n[63] ^ d[63], q);
    endfunction

    function automatic word_t poly_value(input word_t x);
        word_t x2;
        word_t x4;
        if (!poly_quintic) return mul_word(x, add_word(x, C43, 1'b1));
        x2 = mul_word(x, x);
        x4 = mul_word(x2, x2);
        return add_word(add_word(mul_word(x4, x), x, 1'b1), ONE, 1'b1);
    endfunction

    function automatic word_t poly_slope(input word_t x);
        word_t x2;
        word_t x4;
        word_t s;
        if (!poly_quintic) return add_word(add_word(x, x, 1'b0), C43, 1'b1);
        x2 = mul_word(x, x);
        x4 = mul_word(x2, x2);
        s = add_word(add_word(add_word(add_word(x4, x4, 1'b0), x4, 1'b0), x4, 1'b0),
                     x4, 1'b0);
        return add_word(s, ONE, 1'b1);
    endfunction

    function automatic root_result_t newton_solve(input logic signed [GUESS_W-1:0] g);
        root_result_t res;
        word_t x;
        word_t fx;
        word_t d;
        logic [63:0] resid;
        logic stopped;
        x = word_t'(g);
        res.steps = '0;
        res.stat = ST_CONVERGED;
        stopped = 1'b0;
        sat_seen = 1'b0;
        fx = poly_value(x);
        resid = abs_word(fx);
        if (sat_seen)
        begin
            res.stat = ST_OVERFLOW;
            stopped = 1'b1;
        end
        while (!stopped && resid > 64'(tolerance) && res.steps < step_limit)
        begin
            d = poly_slope(x);
            if (sat_seen)
            begin
                res.stat = ST_OVERFLOW;
                stopped = 1'b1;
            end
            else if (d == 0)
            begin
                res.stat = ST_ZERO_DERIV;
                stopped = 1'b1;
            end
            else
            begin
                x = add_word(x, div_word(fx, d), 1'b1);
                res.steps = res.steps + STEP_W'(1);
                if (sat_seen)
                begin
                    res.stat = ST_OVERFLOW;
                    stopped = 1'b1;
                end
                else
                begin
                    fx = poly_value(x);
                    resid = abs_word(fx);
                    if (sat_seen)
                    begin
                        res.stat = ST_OVERFLOW;
                        stopped = 1'b1;
                    end
                end
            end
        end
        if (!stopped) res.stat = (resid <= 64'(tolerance)) ? ST_CONVERGED : ST_STEP_LIMIT;
        res.root = x;
        return res;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_FUNC_SEL:  poly_quintic = val[0];
            CFG_MAX_STEPS: step_limit = val[STEP_W-1:0];
            default:       tolerance = val;
        endcase
    endtask

    task automatic send_guess(input logic signed [GUESS_W-1:0] g, input logic has_fixed,
                              input root_result_t fixed);
        root_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_point <= g;
        res = has_fixed ? fixed : newton_solve(g);
        do @(posedge clk); while (in_stall);
        pending_roots.push_back(res);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic logic signed [GUESS_W-1:0] random_guess(input int kind);
        logic signed [GUESS_W-1:0] g;
        g = GUESS_W'({$urandom, $urandom});
        case (kind)
            0: return g;
            1: return g >>> ($urandom_range(10, 4));
            default: return g >>> 34;
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        root_result_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_roots.size() == 0)
            begin
                $error("unexpected transfer: root_estimate %h", root_estimate);
                fail_count++;
            end
            else
            begin
                e = pending_roots.pop_front();
                if (root_estimate !== e.root)
                begin
                    $error("root_estimate: expected %h, actual %h", e.root, root_estimate);
                    fail_count++;
                end
                if (steps_used !== e.steps)
                begin
                    $error("steps_used: expected %0d, actual %0d", e.steps, steps_used);
                    fail_count++;
                end
                if (status !== e.stat)
                begin
                    $error("status: expected %0d, actual %0d", e.stat, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        guess_row_t rows[$];
        guess_row_t row;
        root_result_t none;
        int phase;
        none = '{root: '0, steps: '0, stat: ST_CONVERGED};
        poly_quintic = 1'b1;
        step_limit = 4'd9;
        tolerance = 32'd1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Quintic rows, including both ends of the guess range.
        rows.push_back('{39'sd0, 1'b0, none});
        rows.push_back('{39'sd1 <<< 32, 1'b0, none});
        rows.push_back('{-(39'sd1 <<< 32), 1'b0, none});
        rows.push_back('{{1'b0, {38{1'b1}}}, 1'b0, none});
        rows.push_back('{{1'b1, 38'd0}, 1'b0, none});
        rows.push_back('{39'sd3 <<< 31, 1'b0, none});
        rows.push_back('{39'sd5 <<< 30, 1'b0, none});
        foreach (rows[i]) send_guess(rows[i].guess, rows[i].has_fixed, rows[i].fixed);
        wait_idle();

        // Zero is an exact root of the quadratic.
        write_register(CFG_FUNC_SEL, 32'd0);
        rows.delete();
        rows.push_back('{39'sd0, 1'b1, '{word_t'(0), 4'd0, ST_CONVERGED}});
        rows.push_back('{39'(C43 >>> 1), 1'b0, none});
        rows.push_back('{39'(C43), 1'b0, none});
        rows.push_back('{39'sd7 <<< 32, 1'b0, none});
        rows.push_back('{{1'b1, 38'd0}, 1'b0, none});
        rows.push_back('{{1'b0, {38{1'b1}}}, 1'b0, none});
        rows.push_back('{-39'sd1, 1'b0, none});
        foreach (rows[i]) send_guess(rows[i].guess, rows[i].has_fixed, rows[i].fixed);
        wait_idle();

        write_register(CFG_MAX_STEPS, 32'd0);
        write_register(CFG_TOLERANCE, 32'd0);
        send_guess(39'sd3 <<< 32, 1'b0, none);
        send_guess(39'sd0, 1'b0, none);
        wait_idle();
        write_register(CFG_MAX_STEPS, 32'd15);
        write_register(CFG_TOLERANCE, 32'hFFFF_FFFF);
        send_guess(39'sd2 <<< 32, 1'b0, none);
        send_guess(39'sd5 <<< 32, 1'b0, none);
        wait_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 61 : 0;
            recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 33 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                write_register(CFG_FUNC_SEL, $urandom_range(1));
                write_register(CFG_MAX_STEPS, (blk == 0) ? 15 : $urandom_range(15));
                write_register(CFG_TOLERANCE, (blk == 1) ? 32'd0 :
                               (blk == 2) ? 32'hFFFF_FFFF : ($urandom >> $urandom_range(31)));
                if (phase == 2 && blk == 0)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3000) @(negedge clk);
                            hold_off = 1'b0;
                        end
                        repeat (4) send_guess(random_guess(1), 1'b0, none);
                    join
                end
                repeat (50) send_guess(random_guess($urandom_range(2)), 1'b0, none);
                wait_idle();
            end
        end

        while (pending_roots.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
